/* sv/affine_floor_row_renderer_macros.svh */
// assertion macros for the floor row renderer
// expects clk and arst_n in the scope of the module that includes it
`ifndef AFFINE_FLOOR_ROW_RENDERER_MACROS_SVH
`define AFFINE_FLOOR_ROW_RENDERER_MACROS_SVH

// same-cycle implication
`define AFFR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AFFR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/affr_pkg.sv */
// shared types and constants of the floor row renderer
// no dependencies
package affr_pkg;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_RENDER = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_WORLD_X   = 3'd0,
		CFG_WORLD_Y   = 3'd1,
		CFG_COS_LEFT  = 3'd2,
		CFG_SIN_LEFT  = 3'd3,
		CFG_COS_RIGHT = 3'd4,
		CFG_SIN_RIGHT = 3'd5
	} cfg_idx_t;

	localparam int ADDR_IN_W   = 18;
	localparam int VALUE_W     = 3;
	localparam int ROW_W       = 6;
	localparam int COLUMN_W    = 4;
	localparam int WORD_W      = 16;
	localparam int WORLD_W     = 21;
	localparam int TRIG_W      = 10;
	localparam int POS_W       = 32;
	localparam int SAMPLE_FRAC = 8;
	localparam int FAR_DIST    = 31;
	localparam int NEAR_DIST   = 5;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 48;

	localparam logic [1:0] PIX_OUTSIDE = 2'd3;

	localparam logic [WORLD_W-1:0] WORLD_X_RESET = 21'd952;
	localparam logic [WORLD_W-1:0] WORLD_Y_RESET = 21'd768;

endpackage

/* sv/affr_ram.sv */
// generic single-port ram, registered read
// no dependencies
module affr_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* sv/affine_floor_row_renderer.sv */
// top level of the perspective floor row renderer: sequencer, shared divider, pixel walk
// depends on affr_pkg, affr_ram and affine_floor_row_renderer_macros.svh
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | tuser opcode, tdata address/value/row
//  m_*     | out       | m_tvalid/m_tready  | tdata row/column/planes, tlast
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a map write word is written to the map ram as it is accepted
// a render word is worked by one shared restoring divider stepping one quotient bit a
// cycle and by the map ram read port giving one texel a cycle, with a drain state and
// a put state per tile to finish a word
// a stalled output holds the walk at the end of the next tile
// reset loads the register defaults; map contents are undefined until written
`include "affine_floor_row_renderer_macros.svh"

module affine_floor_row_renderer #(
	parameter int MAP_SHIFT    = 9,
	parameter int ROW_COUNT    = 64,
	parameter int TILE_COLUMNS = 16,
	parameter int TRIG_SHIFT   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic                               s_tuser,   // opcode
	input  logic [affr_pkg::IN_DATA_W-1:0]     s_tdata,   // map_address, map_value, row
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [affr_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_row, column, plane0, plane1
	output logic                               m_tlast,   // last
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [affr_pkg::WORLD_W-1:0]       cfg_data
);

	import affr_pkg::*;

	localparam int AW     = 2 * MAP_SHIFT;
	localparam int DIV_W  = 16 - TRIG_SHIFT + $clog2(ROW_COUNT);
	localparam int SPAN_W = DIV_W + 1;
	localparam int STEP_W = $clog2(DIV_W);
	localparam int COL_W  = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
	localparam int OOB_LO = MAP_SHIFT + SAMPLE_FRAC;
	localparam logic [POS_W-1:0] PIX_PER_ROW = POS_W'(TILE_COLUMNS * 8);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_DLOAD, ST_DSTEP, ST_SETUP, ST_WALK, ST_DRAIN, ST_PUT
	} state_t;

	function automatic logic signed [POS_W-1:0] trig_off(input logic [TRIG_W-1:0] t,
			input int mult);
		logic signed [POS_W-1:0] p;
		p = $signed({{(POS_W-TRIG_W){t[TRIG_W-1]}}, t}) * $signed(POS_W'(mult));
		return p >>> TRIG_SHIFT;
	endfunction

	state_t state_q;

	logic [WORLD_W-1:0] wx_q, wy_q;
	logic [TRIG_W-1:0]  cl_q, sl_q, cr_q, sr_q;

	logic [ROW_W-1:0]            row_q;
	logic [ROW_W-1:0]            dvs_q;
	logic signed [POS_W-1:0]     near_q [4];
	logic signed [SPAN_W-1:0]    span_q [4];
	logic signed [POS_W-1:0]     sum_q  [4];
	logic [1:0]                  k_q;
	logic [STEP_W-1:0]           step_q;
	logic [DIV_W-1:0]            mag_q;
	logic [ROW_W-1:0]            rem_q;
	logic                        neg_q;

	logic [POS_W-1:0] ax_q, ay_q, dx_q, dy_q;
	logic [2:0]       pix_q;
	logic [COL_W-1:0] col_q;
	logic             v_s1, oob_s1;
	logic [WORD_W-1:0] w0_q, w1_q;

	logic [ROW_W-1:0]    o_row_q;
	logic [COLUMN_W-1:0] o_col_q;
	logic [WORD_W-1:0]   o_p0_q, o_p1_q;
	logic                o_last_q, o_valid_q;

	// input word fields
	logic [ADDR_IN_W-1:0] in_addr;
	logic [VALUE_W-1:0]   in_value;
	logic [ROW_W-1:0]     in_row;
	logic                 in_acc;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr, rd_addr;
	logic [VALUE_W-1:0]   ram_rdata;
	logic [POS_W-1:0]     waddr_full;

	assign in_addr  = s_tdata[ADDR_IN_W-1:0];
	assign in_value = s_tdata[ADDR_IN_W +: VALUE_W];
	assign in_row   = s_tdata[ADDR_IN_W+VALUE_W +: ROW_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign ram_we   = in_acc && (s_tuser == OP_WRITE);
	assign waddr_full = POS_W'(in_addr);
	assign rd_addr  = {ay_q[OOB_LO-1:SAMPLE_FRAC], ax_q[OOB_LO-1:SAMPLE_FRAC]};
	assign ram_addr = ram_we ? waddr_full[AW-1:0] : rd_addr;

	affr_ram #(.WIDTH(VALUE_W), .DEPTH(1 << AW)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_value),
		.rdata (ram_rdata)
	);

	// edge geometry
	logic [TRIG_W-1:0]       trig [4];
	logic [WORLD_W-1:0]      base [4];
	logic signed [POS_W-1:0] near_c [4];
	logic signed [POS_W-1:0] span_c [4];

	always_comb begin
		trig[0] = cl_q; base[0] = wx_q;
		trig[1] = sl_q; base[1] = wy_q;
		trig[2] = cr_q; base[2] = wx_q;
		trig[3] = sr_q; base[3] = wy_q;
		for (int i = 0; i < 4; i++) begin
			near_c[i] = $signed({{(POS_W-WORLD_W){base[i][WORLD_W-1]}}, base[i]})
				+ trig_off(trig[i], NEAR_DIST);
			span_c[i] = (trig_off(trig[i], FAR_DIST) - trig_off(trig[i], NEAR_DIST))
				* $signed(POS_W'(ROW_COUNT));
		end
	end

	// divider step
	logic [ROW_W:0]          trial;
	logic                    qbit;
	logic [DIV_W-1:0]        quot;
	logic signed [POS_W-1:0] quot_s;
	logic [SPAN_W-1:0]       span_abs;

	always_comb begin
		trial    = {rem_q, mag_q[DIV_W-1]};
		qbit     = (trial >= {1'b0, dvs_q});
		quot     = {mag_q[DIV_W-2:0], qbit};
		quot_s   = neg_q ? -$signed(POS_W'(quot)) : $signed(POS_W'(quot));
		span_abs = span_q[k_q][SPAN_W-1] ? SPAN_W'(-span_q[k_q]) : span_q[k_q];
	end

	// pixel colour from the read data
	logic [1:0] v0, v1;
	always_comb begin
		v0 = 2'd0;
		v1 = 2'd0;
		if (oob_s1) begin
			v0 = PIX_OUTSIDE;
		end else if (ram_rdata[2]) begin
			v1 = 2'(ram_rdata - VALUE_W'(3));
		end else begin
			v0 = ram_rdata[1:0];
		end
	end

	logic slot_free, last_col;
	assign slot_free = !o_valid_q || m_tready;
	assign last_col  = (col_q == COL_W'(TILE_COLUMNS - 1));

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q <= WORLD_X_RESET;
			wy_q <= WORLD_Y_RESET;
			cl_q <= '0;
			sl_q <= '0;
			cr_q <= '0;
			sr_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WORLD_X:   wx_q <= cfg_data;
				CFG_WORLD_Y:   wy_q <= cfg_data;
				CFG_COS_LEFT:  cl_q <= cfg_data[TRIG_W-1:0];
				CFG_SIN_LEFT:  sl_q <= cfg_data[TRIG_W-1:0];
				CFG_COS_RIGHT: cr_q <= cfg_data[TRIG_W-1:0];
				CFG_SIN_RIGHT: sr_q <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			o_valid_q <= 1'b0;
			v_s1      <= 1'b0;
			k_q       <= '0;
			step_q    <= '0;
			pix_q     <= '0;
			col_q     <= '0;
		end else begin
			if (m_tready && !(state_q == ST_PUT && slot_free)) begin
				o_valid_q <= 1'b0;
			end
			if (v_s1) begin
				w0_q <= {w0_q[WORD_W-3:0], v0};
				w1_q <= {w1_q[WORD_W-3:0], v1};
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == OP_RENDER) begin
						row_q   <= in_row;
						dvs_q   <= (in_row == '0) ? ROW_W'(1) : in_row;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					for (int i = 0; i < 4; i++) begin
						near_q[i] <= near_c[i];
						span_q[i] <= span_c[i][SPAN_W-1:0];
					end
					k_q     <= '0;
					state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					mag_q   <= span_abs[DIV_W-1:0];
					neg_q   <= span_q[k_q][SPAN_W-1];
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					rem_q  <= qbit ? ROW_W'(trial - {1'b0, dvs_q}) : trial[ROW_W-1:0];
					mag_q  <= quot;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_W - 1)) begin
						sum_q[k_q] <= quot_s + near_q[k_q];
						k_q        <= k_q + 2'd1;
						state_q    <= (k_q == 2'd3) ? ST_SETUP : ST_DLOAD;
					end
				end
				ST_SETUP: begin
					ax_q    <= POS_W'(sum_q[0] * $signed(PIX_PER_ROW));
					ay_q    <= POS_W'(sum_q[1] * $signed(PIX_PER_ROW));
					dx_q    <= POS_W'(sum_q[2] - sum_q[0]);
					dy_q    <= POS_W'(sum_q[3] - sum_q[1]);
					pix_q   <= '0;
					col_q   <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					v_s1   <= 1'b1;
					oob_s1 <= (ax_q[POS_W-1:OOB_LO] != '0) || (ay_q[POS_W-1:OOB_LO] != '0);
					ax_q   <= ax_q + dx_q;
					ay_q   <= ay_q + dy_q;
					pix_q  <= pix_q + 3'd1;
					if (pix_q == 3'd7) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					v_s1    <= 1'b0;
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (slot_free) begin
						o_valid_q <= 1'b1;
						o_row_q   <= row_q;
						o_col_q   <= COLUMN_W'(col_q);
						o_p0_q    <= w0_q;
						o_p1_q    <= w1_q;
						o_last_q  <= last_col;
						col_q     <= col_q + COL_W'(1);
						state_q   <= last_col ? ST_IDLE : ST_WALK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {OUT_DATA_W'({o_p1_q, o_p0_q, o_col_q, o_row_q})};

	`AFFR_ASSERT_NOW(a_ram_write_idle, ram_we, state_q == ST_IDLE,
		"map write outside idle")
	`AFFR_ASSERT_NEXT(a_render_starts, in_acc && s_tuser == OP_RENDER, state_q == ST_PREP,
		"render word did not start the sequencer")
	`AFFR_ASSERT_NEXT(a_last_tile_done, state_q == ST_PUT && slot_free && last_col,
		state_q == ST_IDLE && m_tvalid && m_tlast, "last tile did not end the row")
	`AFFR_ASSERT_NOW(a_no_pixel_outside_walk, v_s1,
		state_q == ST_WALK || state_q == ST_DRAIN, "texel in flight outside the walk")

endmodule

/* dv/tb_affine_floor_row_renderer.sv */
// self-checking testbench for affine_floor_row_renderer: map writes, directed and random items
// depends on affr_pkg and the affine_floor_row_renderer rtl
`timescale 1ns / 1ps

class floor_row_scoreboard;
	typedef struct {
		logic [5:0]  row;
		logic [3:0]  column;
		logic [15:0] plane0;
		logic [15:0] plane1;
		logic        last;
	} tile_word_t;

	tile_word_t  tile_words[$];
	logic [2:0]  texels[262144];
	bit          written[262144];
	logic signed [20:0] world_x, world_y;
	logic signed [9:0]  cos_left, sin_left, cos_right, sin_right;
	int errors;

	function new();
		world_x = affr_pkg::WORLD_X_RESET;
		world_y = affr_pkg::WORLD_Y_RESET;
		cos_left = '0; sin_left = '0; cos_right = '0; sin_right = '0;
		errors = 0;
	endfunction

	function void set_register(logic [2:0] index, logic [20:0] value);
		case (index)
			affr_pkg::CFG_WORLD_X:   world_x = value;
			affr_pkg::CFG_WORLD_Y:   world_y = value;
			affr_pkg::CFG_COS_LEFT:  cos_left = value[9:0];
			affr_pkg::CFG_SIN_LEFT:  sin_left = value[9:0];
			affr_pkg::CFG_COS_RIGHT: cos_right = value[9:0];
			affr_pkg::CFG_SIN_RIGHT: sin_right = value[9:0];
			default: ;
		endcase
	endfunction

	function automatic void edge_points(int base, int trig, output int near_pt, output int span);
		int far_pt;
		far_pt = base + ((trig * affr_pkg::FAR_DIST) >>> 8);
		near_pt = base + ((trig * affr_pkg::NEAR_DIST) >>> 8);
		span = (far_pt - near_pt) * 64;
	endfunction

	// start position and per-pixel step of a row
	function void row_geometry(logic [5:0] row, output bit [31:0] ax, output bit [31:0] ay,
			output bit [31:0] dx_u, output bit [31:0] dy_u);
		int n1x, n1y, n2x, n2y, f1x, f1y, f2x, f2y, dv, sx, sy, dx, dy;
		edge_points(world_x, cos_left, n1x, f1x);
		edge_points(world_y, sin_left, n1y, f1y);
		edge_points(world_x, cos_right, n2x, f2x);
		edge_points(world_y, sin_right, n2y, f2y);
		dv = (row == 0) ? 1 : int'(row);
		sx = f1x / dv + n1x;
		sy = f1y / dv + n1y;
		dx = f2x / dv + n2x - sx;
		dy = f2y / dv + n2y - sy;
		ax = sx * 128;
		ay = sy * 128;
		dx_u = dx;
		dy_u = dy;
	endfunction

	// first in-map texel of the row that was never written
	function bit find_unwritten(logic [5:0] row, output logic [17:0] addr);
		bit [31:0] ax, ay, dx, dy;
		row_geometry(row, ax, ay, dx, dy);
		addr = '0;
		for (int p = 0; p < 128; p++) begin
			if ((ax & 32'hfffe0000) == 0 && (ay & 32'hfffe0000) == 0
					&& !written[{ay[16:8], ax[16:8]}]) begin
				addr = {ay[16:8], ax[16:8]};
				return 1'b1;
			end
			ax += dx;
			ay += dy;
		end
		return 1'b0;
	endfunction

	function void render_row(logic [5:0] row);
		bit [31:0] ax, ay, dx, dy;
		logic [2:0] c;
		tile_word_t tw;
		row_geometry(row, ax, ay, dx, dy);
		for (int col = 0; col < 16; col++) begin
			tw.row = row;
			tw.column = 4'(col);
			tw.plane0 = '0;
			tw.plane1 = '0;
			tw.last = (col == 15);
			for (int p = 0; p < 8; p++) begin
				tw.plane0 = tw.plane0 << 2;
				tw.plane1 = tw.plane1 << 2;
				if ((ax & 32'hfffe0000) != 0 || (ay & 32'hfffe0000) != 0) begin
					tw.plane0[1:0] = affr_pkg::PIX_OUTSIDE;
				end else begin
					c = texels[{ay[16:8], ax[16:8]}];
					// colours 4..7 land on the second plane, 7 wraps to 0
					if (c[2]) tw.plane1[1:0] = 2'(c - 3'd3);
					else tw.plane0[1:0] = c[1:0];
				end
				ax += dx;
				ay += dy;
			end
			tile_words.push_back(tw);
		end
	endfunction

	function void note_input(logic op, logic [17:0] addr, logic [2:0] value, logic [5:0] row);
		if (op == affr_pkg::OP_WRITE) begin
			texels[addr] = value;
			written[addr] = 1'b1;
		end else begin
			render_row(row);
		end
	endfunction

	function void check_word(logic [47:0] data, logic last);
		tile_word_t exp_w;
		if (tile_words.size() == 0) begin
			$error("unexpected word %h", data);
			errors++;
			return;
		end
		exp_w = tile_words.pop_front();
		if (data[5:0] !== exp_w.row) begin
			$error("out_row exp %0d got %0d", exp_w.row, data[5:0]); errors++;
		end
		if (data[9:6] !== exp_w.column) begin
			$error("column exp %0d got %0d", exp_w.column, data[9:6]); errors++;
		end
		if (data[25:10] !== exp_w.plane0) begin
			$error("plane0_word exp %h got %h", exp_w.plane0, data[25:10]); errors++;
		end
		if (data[41:26] !== exp_w.plane1) begin
			$error("plane1_word exp %h got %h", exp_w.plane1, data[41:26]); errors++;
		end
		if (last !== exp_w.last) begin
			$error("last exp %0d got %0d", exp_w.last, last); errors++;
		end
	endfunction
endclass

module tb_affine_floor_row_renderer;
	import affr_pkg::*;

	localparam int CYCLE_LIMIT = 2500000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tuser = 0, m_tready = 0, cfg_valid = 0;
	logic s_tready, m_tvalid, m_tlast, cfg_ready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0] cfg_index = '0;
	logic [WORLD_W-1:0] cfg_data = '0;

	floor_row_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	int cycles = 0;

	affine_floor_row_renderer dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_affine_floor_row_renderer failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 0;
				repeat (3000) @(posedge clk);
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= 15);
		end
	end

	task automatic send_item(logic op, logic [17:0] addr, logic [2:0] value, logic [5:0] row);
		while (!quiet && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {5'b0, row, value, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, addr, value, row);
	endtask

	// writes every texel the row would sample before rendering it
	task automatic send_render(logic [5:0] row);
		logic [17:0] a;
		while (sb.find_unwritten(row, a))
			send_item(OP_WRITE, a, 3'($urandom), 6'($urandom));
		send_item(OP_RENDER, 18'($urandom), 3'($urandom), row);
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (sb.tile_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] index, logic [20:0] value);
		cfg_valid <= 1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(index, value);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [20:0] pick_world(int sel);
		case (sel)
			0: return 21'h0fffff;
			1: return 21'h100000;
			2: return 21'd0;
			default: return 21'($urandom_range(0, 1100));
		endcase
	endfunction

	function automatic logic [20:0] pick_trig(int sel);
		case (sel)
			0: return 21'(256);
			1: return 21'(-256);
			2: return 21'($urandom);
			default: return 21'($urandom_range(0, 512) - 256);
		endcase
	endfunction

	// a render that would sample an unwritten texel becomes a write to it
	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			logic [17:0] a;
			logic [5:0]  r;
			r = 6'($urandom);
			if ($urandom_range(0, 99) < 30)
				send_item(OP_WRITE, 18'($urandom), 3'($urandom), r);
			else if (sb.find_unwritten(r, a))
				send_item(OP_WRITE, a, 3'($urandom), r);
			else
				send_item(OP_RENDER, 18'($urandom), 3'($urandom), r);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings sample one texel, every colour code, row extremes
		for (int v = 0; v < 8; v++) begin
			send_item(OP_WRITE, {9'd384, 9'd476}, 3'(v), '0);
			send_item(OP_RENDER, '0, '0, 6'(v * 9));
		end
		send_item(OP_WRITE, 18'h3ffff, 3'd7, 6'h3f);
		send_item(OP_WRITE, 18'h00000, 3'd6, 6'h00);
		send_item(OP_RENDER, 18'h3ffff, 3'd7, 6'd32);
		wait_drained();

		write_register(CFG_WORLD_X, 21'd500);
		write_register(CFG_WORLD_Y, 21'd400);
		write_register(CFG_COS_LEFT, 21'(256));
		write_register(CFG_SIN_LEFT, 21'(-256));
		write_register(CFG_COS_RIGHT, 21'(-256));
		write_register(CFG_SIN_RIGHT, 21'(256));
		write_register(3'd6, 21'h1fffff);
		write_register(3'd7, 21'h0);
		send_render(6'd1);
		send_render(6'd63);
		send_render(6'd0);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			logic [20:0] tc, ts;
			write_register(CFG_WORLD_X, pick_world(ph == 0 ? 0 : ph == 1 ? 1 : 3 + ph));
			write_register(CFG_WORLD_Y, pick_world(ph == 0 ? 1 : ph == 2 ? 2 : 3 + ph));
			tc = pick_trig(ph % 4);
			ts = pick_trig((ph + 1) % 4);
			write_register(CFG_COS_LEFT, tc);
			write_register(CFG_SIN_LEFT, ts);
			// middle phases use equal edges so each row samples a single texel
			if (ph < 2 || ph == 7) begin
				write_register(CFG_COS_RIGHT, pick_trig((ph + 2) % 4));
				write_register(CFG_SIN_RIGHT, pick_trig((ph + 3) % 4));
			end else begin
				write_register(CFG_COS_RIGHT, tc);
				write_register(CFG_SIN_RIGHT, ts);
			end
			if (ph == 4) write_register(3'($urandom_range(6, 7)), 21'($urandom));
			quiet = (ph == 5);
			if (ph == 3) hold_req = 1;
			random_items(42);
			wait_drained();
		end
		quiet = 0;

		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.tile_words.size() == 0) begin
			$display("tb_affine_floor_row_renderer passed");
		end else begin
			$display("tb_affine_floor_row_renderer failed");
		end
		$finish;
	end
endmodule

/* affine_floor_row_renderer.f */
+incdir+sv
sv/affr_pkg.sv
sv/affr_ram.sv
sv/affine_floor_row_renderer.sv
dv/tb_affine_floor_row_renderer.sv
